FILE: rtl/bcu_pkg.sv
// Shared types, constants and helpers for the barometric compensation unit.
// No dependencies.
`default_nettype none
package bcu_pkg;
    localparam int CAL_WORDS = 6;
    localparam int CAL_IDX_W = 3;
    localparam int DIV_STEPS = 32;

    typedef struct packed {
        logic [15:0] t1;
        logic [15:0] t2;
        logic [15:0] t3;
        logic [15:0] p1;
        logic [15:0] p2;
        logic [15:0] p3;
        logic [15:0] p4;
        logic [15:0] p5;
        logic [15:0] p6;
        logic [15:0] p7;
        logic [15:0] p8;
        logic [15:0] p9;
    } cal_t;

    // pressure front-end result handed to the divider
    typedef struct packed {
        logic [23:0] temp;
        logic [31:0] fine;
        logic [31:0] num;
        logic [31:0] den;
        logic        big;
        logic        invalid;
    } div_in_t;

    typedef struct packed {
        logic [23:0] temp;
        logic [31:0] fine;
        logic [31:0] quo;
        logic        big;
        logic        invalid;
    } div_out_t;

    function automatic logic [31:0] sx16(input logic [15:0] v);
        sx16 = {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] r;
        r = a * b;
        mul32 = r[31:0];
    endfunction

    function automatic logic [31:0] asr(input logic [31:0] x, input int n);
        asr = 32'($signed(x) >>> n);
    endfunction
endpackage
`default_nettype wire

FILE: rtl/barometric_compensation_unit.sv
// Top level of the barometric compensation unit: config registers and pipeline.
// Depends on bcu_pkg, bcu_front, bcu_div, bcu_back.
//
// Usage:
//  - s_axis carries one raw sample set per beat (pressure and temperature bytes).
//  - m_axis gives one beat per sample set: temperature, fine temperature,
//    pressure and an invalid flag (zero divisor, pressure forced to 0).
//  - cfg_* writes the six calibration words; index 0..5, others ignored.
//    Always ready. Write only while no beat is in flight.
//  - The pipeline has 9 front-end stages, 32 divider stages and 3 back-end
//    stages from input beat to output valid; the divider sets the depth.
//  - Throughput: one beat per cycle while the pipeline is not held.
//  - The pipeline holds only while a finished result waits and m_axis_tready
//    is low; s_axis_tready drops only then, so nothing is lost or repeated.
//  - Reset clears all valid bits and calibration words to zero.
`default_nettype none
module barometric_compensation_unit
    import bcu_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // press_msb, press_lsb, press_xlsb, temp_msb, temp_lsb, temp_xlsb
    input  wire logic [47:0]          s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // temperature_centideg, fine_temperature, pressure_pa
    output logic [87:0]               m_axis_tdata,
    // pressure_invalid
    output logic                      m_axis_tuser,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CAL_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data
);
    logic [31:0] cal_reg [CAL_WORDS];
    cal_t        cal;
    logic        en;
    logic        f_valid, d_valid, b_valid;
    div_in_t     f_data;
    div_out_t    d_data;
    logic [23:0] temp;
    logic [31:0] fine, press;
    logic        invalid;
    logic [19:0] adc_t, adc_p;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CAL_WORDS; i++)
                cal_reg[i] <= '0;
        end
        else if (cfg_valid && (32'(cfg_index) < CAL_WORDS))
            cal_reg[cfg_index] <= cfg_data;
    end

    assign cal = '{t1: cal_reg[0][15:0], t2: cal_reg[0][31:16],
                   t3: cal_reg[1][15:0], p1: cal_reg[1][31:16],
                   p2: cal_reg[2][15:0], p3: cal_reg[2][31:16],
                   p4: cal_reg[3][15:0], p5: cal_reg[3][31:16],
                   p6: cal_reg[4][15:0], p7: cal_reg[4][31:16],
                   p8: cal_reg[5][15:0], p9: cal_reg[5][31:16]};

    assign adc_p = {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:20]};
    assign adc_t = {s_axis_tdata[31:24], s_axis_tdata[39:32], s_axis_tdata[47:44]};

    // pipeline advances unless a finished result is stuck at the output
    assign en            = !b_valid || m_axis_tready;
    assign s_axis_tready = en;

    bcu_front u_front (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s_axis_tvalid),
        .adc_t(adc_t), .adc_p(adc_p), .cal(cal),
        .out_valid(f_valid), .out_data(f_data)
    );

    bcu_div u_div (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(f_valid), .in_data(f_data),
        .out_valid(d_valid), .out_data(d_data)
    );

    bcu_back u_back (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(d_valid), .in_data(d_data),
        .cal(cal), .out_valid(b_valid), .temp(temp), .fine(fine),
        .press(press), .invalid(invalid)
    );

    assign m_axis_tvalid = b_valid;
    assign m_axis_tdata  = {press, fine, temp};
    assign m_axis_tuser  = invalid;
endmodule
`default_nettype wire

FILE: rtl/bcu_front.sv
// Pipelined temperature and pressure front end: raw readings to divider operands.
// Depends on bcu_pkg.
`default_nettype none
module bcu_front
    import bcu_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        en,
    input  wire logic        in_valid,
    input  wire logic [19:0] adc_t,
    input  wire logic [19:0] adc_p,
    input  wire cal_t        cal,
    output logic             out_valid,
    output div_in_t          out_data
);
    localparam int NST = 9;
    logic [NST-1:0] v_reg;

    // stage registers
    logic [19:0] s1_adcp_reg, s2_adcp_reg, s3_adcp_reg, s4_adcp_reg, s5_adcp_reg;
    logic [19:0] s6_adcp_reg, s7_adcp_reg;
    logic [31:0] s1_x_reg, s1_d_reg;
    logic [31:0] s2_a_reg, s2_dd_reg;
    logic [31:0] s3_a_reg, s3_b_reg;
    logic [31:0] s4_fine_reg, s4_t5_reg, s4_pa_reg, s4_q_reg;
    logic [31:0] s5_fine_reg, s5_temp_reg, s5_qq_reg, s5_ap5_reg, s5_p2a_reg;
    logic [31:0] s6_fine_reg, s6_temp_reg, s6_b6_reg, s6_p3q_reg, s6_p2a_reg, s6_qq11_reg;
    logic [31:0] s7_fine_reg, s7_temp_reg, s7_b_reg, s7_a_reg;
    logic [31:0] s8_fine_reg, s8_temp_reg, s8_num_reg, s8_den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[NST-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_adcp_reg <= adc_p;
            s1_x_reg    <= 32'(adc_t >> 3) - (32'(cal.t1) << 1);
            s1_d_reg    <= 32'(adc_t >> 4) - 32'(cal.t1);

            s2_adcp_reg <= s1_adcp_reg;
            s2_a_reg    <= asr(mul32(s1_x_reg, sx16(cal.t2)), 11);
            s2_dd_reg   <= asr(mul32(s1_d_reg, s1_d_reg), 12);

            s3_adcp_reg <= s2_adcp_reg;
            s3_a_reg    <= s2_a_reg;
            s3_b_reg    <= asr(mul32(s2_dd_reg, sx16(cal.t3)), 14);

            s4_adcp_reg <= s3_adcp_reg;
            s4_fine_reg <= s3_a_reg + s3_b_reg;
            s4_t5_reg   <= mul32(s3_a_reg + s3_b_reg, 32'd5) + 32'd128;
            s4_pa_reg   <= asr(s3_a_reg + s3_b_reg, 1) - 32'd64000;
            s4_q_reg    <= asr(asr(s3_a_reg + s3_b_reg, 1) - 32'd64000, 2);

            s5_adcp_reg <= s4_adcp_reg;
            s5_fine_reg <= s4_fine_reg;
            s5_temp_reg <= asr(s4_t5_reg, 8);
            s5_qq_reg   <= mul32(s4_q_reg, s4_q_reg);
            s5_ap5_reg  <= mul32(s4_pa_reg, sx16(cal.p5));
            s5_p2a_reg  <= asr(mul32(sx16(cal.p2), s4_pa_reg), 1);

            s6_adcp_reg <= s5_adcp_reg;
            s6_fine_reg <= s5_fine_reg;
            s6_temp_reg <= s5_temp_reg;
            s6_qq11_reg <= asr(s5_qq_reg, 11);
            s6_b6_reg   <= s5_ap5_reg << 1;
            s6_p3q_reg  <= asr(mul32(sx16(cal.p3), asr(s5_qq_reg, 13)), 3);
            s6_p2a_reg  <= s5_p2a_reg;

            s7_adcp_reg <= s6_adcp_reg;
            s7_fine_reg <= s6_fine_reg;
            s7_temp_reg <= s6_temp_reg;
            s7_b_reg    <= asr(mul32(s6_qq11_reg, sx16(cal.p6)) + s6_b6_reg, 2)
                           + (sx16(cal.p4) << 16);
            s7_a_reg    <= 32'd32768 + asr(s6_p3q_reg + s6_p2a_reg, 18);

            s8_fine_reg <= s7_fine_reg;
            s8_temp_reg <= s7_temp_reg;
            s8_num_reg  <= mul32((32'd1048576 - 32'(s7_adcp_reg)) - asr(s7_b_reg, 12),
                                 32'd3125);
            s8_den_reg  <= asr(mul32(s7_a_reg, 32'(cal.p1)), 15);

            out_data.temp    <= s8_temp_reg[23:0];
            out_data.fine    <= s8_fine_reg;
            out_data.num     <= s8_num_reg[31] ? s8_num_reg : (s8_num_reg << 1);
            out_data.den     <= s8_den_reg;
            out_data.big     <= s8_num_reg[31];
            out_data.invalid <= (s8_den_reg == '0);
        end
    end

    assign out_valid = v_reg[NST-1];
endmodule
`default_nettype wire

FILE: rtl/bcu_div.sv
// Pipelined 32-bit unsigned restoring divider, one quotient bit per stage.
// Depends on bcu_pkg.
`default_nettype none
module bcu_div
    import bcu_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    en,
    input  wire logic    in_valid,
    input  wire div_in_t in_data,
    output logic         out_valid,
    output div_out_t     out_data
);
    logic [DIV_STEPS-1:0] v_reg;
    logic [31:0] rem_reg [DIV_STEPS];
    logic [31:0] num_reg [DIV_STEPS];
    logic [31:0] quo_reg [DIV_STEPS];
    logic [31:0] den_reg [DIV_STEPS];
    div_out_t    side_reg [DIV_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[DIV_STEPS-2:0], in_valid};
    end

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_step
        logic [31:0] r_in, n_in, q_in, d_in;
        div_out_t    s_in;
        logic [32:0] trial;
        if (i == 0)
        begin : g_first
            assign r_in = '0;
            assign n_in = in_data.num;
            assign q_in = '0;
            assign d_in = in_data.den;
            assign s_in = '{temp: in_data.temp, fine: in_data.fine, quo: '0,
                            big: in_data.big, invalid: in_data.invalid};
        end
        else
        begin : g_rest
            assign r_in = rem_reg[i-1];
            assign n_in = num_reg[i-1];
            assign q_in = quo_reg[i-1];
            assign d_in = den_reg[i-1];
            assign s_in = side_reg[i-1];
        end
        assign trial = {r_in, n_in[31]} - {1'b0, d_in};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!trial[32])
                begin
                    rem_reg[i] <= trial[31:0];
                    quo_reg[i] <= {q_in[30:0], 1'b1};
                end
                else
                begin
                    rem_reg[i] <= {r_in[30:0], n_in[31]};
                    quo_reg[i] <= {q_in[30:0], 1'b0};
                end
                num_reg[i]  <= {n_in[30:0], 1'b0};
                den_reg[i]  <= d_in;
                side_reg[i] <= s_in;
            end
        end
    end

    always_comb
    begin
        out_data     = side_reg[DIV_STEPS-1];
        out_data.quo = quo_reg[DIV_STEPS-1];
    end
    assign out_valid = v_reg[DIV_STEPS-1];
endmodule
`default_nettype wire

FILE: rtl/bcu_back.sv
// Pressure back end: scaling of the quotient and the final P7..P9 correction.
// Depends on bcu_pkg.
`default_nettype none
module bcu_back
    import bcu_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     en,
    input  wire logic     in_valid,
    input  wire div_out_t in_data,
    input  wire cal_t     cal,
    output logic          out_valid,
    output logic [23:0]   temp,
    output logic [31:0]   fine,
    output logic [31:0]   press,
    output logic          invalid
);
    logic [2:0]  v_reg;
    logic [23:0] t1_reg, t2_reg;
    logic [31:0] f1_reg, f2_reg;
    logic        i1_reg, i2_reg;
    logic [31:0] p1_reg, p2_reg, pp_reg, b_reg, a_reg;
    logic [31:0] p_q;
    logic [28:0] p3s;

    assign p_q = in_data.big ? (in_data.quo << 1) : in_data.quo;
    assign p3s = p_q[31:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_reg <= in_data.temp;
            f1_reg <= in_data.fine;
            i1_reg <= in_data.invalid;
            p1_reg <= p_q;
            pp_reg <= mul32(32'(p3s), 32'(p3s)) >> 13;
            b_reg  <= asr(mul32(32'(p_q[31:2]), sx16(cal.p8)), 13);

            t2_reg <= t1_reg;
            f2_reg <= f1_reg;
            i2_reg <= i1_reg;
            p2_reg <= p1_reg;
            a_reg  <= asr(mul32(sx16(cal.p9), pp_reg), 12) + b_reg + sx16(cal.p7);

            temp    <= t2_reg;
            fine    <= f2_reg;
            invalid <= i2_reg;
            press   <= i2_reg ? '0 : p2_reg + asr(a_reg, 4);
        end
    end

    assign out_valid = v_reg[2];
endmodule
`default_nettype wire

FILE: bench/tb_barometric_compensation_unit.sv
// Self-checking bench for barometric_compensation_unit: random raw sample sets
// under several calibration settings, predicted in-bench. Depends on bcu_pkg and the RTL.
`timescale 1ns / 100ps

class comp_scoreboard;
    logic [23:0] exp_temp[$];
    logic [31:0] exp_fine[$];
    logic [31:0] exp_press[$];
    logic        exp_inv[$];
    logic [31:0] cal[6];
    int          errors;
    int          checked;
    int          invalid_seen;

    function logic [31:0] sar(logic [31:0] x, int n);
        return 32'($signed(x) >>> n);
    endfunction

    function logic [31:0] m32(logic [31:0] a, logic [31:0] b);
        logic [63:0] r;
        r = {32'd0, a} * {32'd0, b};
        return r[31:0];
    endfunction

    function logic [31:0] s16(logic [31:0] w, int sh);
        logic [15:0] v;
        v = 16'(w >> sh);
        return {{16{v[15]}}, v};
    endfunction

    function void note_sample(logic [47:0] d);
        logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [31:0] adc_p, adc_t, a, b, dd, fine, temp, p, q;
        logic        inv;
        t1 = {16'd0, cal[0][15:0]};
        t2 = s16(cal[0], 16);
        t3 = s16(cal[1], 0);
        p1 = {16'd0, cal[1][31:16]};
        p2 = s16(cal[2], 0);
        p3 = s16(cal[2], 16);
        p4 = s16(cal[3], 0);
        p5 = s16(cal[3], 16);
        p6 = s16(cal[4], 0);
        p7 = s16(cal[4], 16);
        p8 = s16(cal[5], 0);
        p9 = s16(cal[5], 16);
        adc_p = {12'd0, d[7:0], d[15:8], d[23:20]};
        adc_t = {12'd0, d[31:24], d[39:32], d[47:44]};
        a = sar(m32((adc_t >> 3) - (t1 << 1), t2), 11);
        dd = (adc_t >> 4) - t1;
        b = sar(m32(sar(m32(dd, dd), 12), t3), 14);
        fine = a + b;
        temp = sar(m32(fine, 5) + 128, 8);
        a = sar(fine, 1) - 32'd64000;
        q = sar(a, 2);
        b = m32(sar(m32(q, q), 11), p6);
        b = b + (m32(a, p5) << 1);
        b = sar(b, 2) + (p4 << 16);
        a = sar(sar(m32(p3, sar(m32(q, q), 13)), 3) + sar(m32(p2, a), 1), 18);
        a = sar(m32(32'd32768 + a, p1), 15);
        inv = (a == 0);
        if (inv)
            p = 0;
        else
        begin
            p = m32((32'd1048576 - adc_p) - sar(b, 12), 32'd3125);
            if (p < 32'h8000_0000)
                p = (p << 1) / a;
            else
                p = (p / a) * 2;
            a = sar(m32(p9, ((p >> 3) * (p >> 3)) >> 13), 12);
            b = sar(m32(p >> 2, p8), 13);
            p = p + sar(a + b + p7, 4);
        end
        exp_temp.push_back(temp[23:0]);
        exp_fine.push_back(fine);
        exp_press.push_back(p);
        exp_inv.push_back(inv);
    endfunction

    function void check_result(logic [87:0] d, logic u);
        if (exp_temp.size() == 0)
        begin
            $error("result beat with nothing expected");
            errors++;
            return;
        end
        checked++;
        if (u)
            invalid_seen++;
        if (d[23:0] !== exp_temp[0])
        begin
            $error("temperature_centideg exp %0h got %0h", exp_temp[0], d[23:0]);
            errors++;
        end
        if (d[55:24] !== exp_fine[0])
        begin
            $error("fine_temperature exp %0h got %0h", exp_fine[0], d[55:24]);
            errors++;
        end
        if (d[87:56] !== exp_press[0])
        begin
            $error("pressure_pa exp %0h got %0h", exp_press[0], d[87:56]);
            errors++;
        end
        if (u !== exp_inv[0])
        begin
            $error("pressure_invalid exp %0b got %0b", exp_inv[0], u);
            errors++;
        end
        void'(exp_temp.pop_front());
        void'(exp_fine.pop_front());
        void'(exp_press.pop_front());
        void'(exp_inv.pop_front());
    endfunction
endclass

module tb_barometric_compensation_unit;
    import bcu_pkg::*;

    localparam int LATENCY = 44;

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    // press_msb, press_lsb, press_xlsb, temp_msb, temp_lsb, temp_xlsb
    logic [47:0]          s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    // temperature_centideg, fine_temperature, pressure_pa
    logic [87:0]          m_axis_tdata;
    // pressure_invalid
    logic                 m_axis_tuser;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CAL_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;

    comp_scoreboard sb;
    bit             no_idle;
    int             samples_sent;

    barometric_compensation_unit dut (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // result side: random backpressure, checks at rising edge
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= no_idle || ($urandom_range(99) >= 28);
    end

    // leaves cfg_valid high; load_cal drops it after the last word
    task automatic write_cal(input int idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= CAL_IDX_W'(idx);
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.cal[idx] = val;
        @(negedge clk);
    endtask

    // tvalid stays high between back-to-back beats; dropped only while idling
    task automatic send_sample(input logic [47:0] d);
        while (!no_idle && $urandom_range(99) < 28)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_sample(d);
        samples_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.exp_temp.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 8) @(negedge clk);
    endtask

    // bytes: press msb/lsb/xlsb, temp msb/lsb/xlsb, lowest first
    function automatic logic [47:0] pack(logic [7:0] pm, pl, px, tm, tl, tx);
        return {tx, tl, tm, px, pl, pm};
    endfunction

    // typical sensor-like readings with random low bits
    function automatic logic [47:0] typical_sample();
        return pack(8'($urandom_range(8'h50, 8'h70)), 8'($urandom), 8'($urandom),
                    8'($urandom_range(8'h70, 8'h90)), 8'($urandom), 8'($urandom));
    endfunction

    task automatic load_cal(input logic [31:0] w0, w1, w2, w3, w4, w5);
        write_cal(0, w0);
        write_cal(1, w1);
        write_cal(2, w2);
        write_cal(3, w3);
        write_cal(4, w4);
        write_cal(5, w5);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_typical_cal();
        // datasheet-like words, jittered within ranges; P6 and P8 fully random
        load_cal({16'(16'd26435 + $urandom_range(2000)), 16'(16'd27504 + $urandom_range(4000))},
                 {16'(16'd36477 + $urandom_range(3000)), 16'(16'hFC18 + $urandom_range(2000))},
                 {16'(16'h0BD0 + $urandom_range(500)), 16'(16'hD5F0 + $urandom_range(3000))},
                 {16'(16'hFF00 + $urandom_range(300)), 16'(16'h2000 + $urandom_range(8000))},
                 {16'(16'h3C00 + $urandom_range(2000)), 16'($urandom)},
                 {16'(16'h1770 + $urandom_range(1000)), 16'($urandom)});
    endtask

    initial
    begin
        #50ms;
        $display("TIMEOUT");
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        sb = new();
        foreach (sb.cal[i])
            sb.cal[i] = '0;
        rst_n         = 1'b0;
        no_idle       = 1'b0;
        samples_sent  = 0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // all-zero calibration: divisor zero, invalid pressure
        send_sample(pack(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_sample(pack(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        drain();

        // directed: typical calibration, field extremes, ignored nibbles
        load_cal({16'd27504, 16'd26435}, {16'd36477, 16'hFC18},
                 {16'hD5F0, 16'h0BD0}, {16'h2000, 16'hFF00},
                 {16'h3C00, 16'hFFF9}, {16'h1770, 16'hC64A});
        send_sample(pack(8'h65, 8'h5A, 8'hC0, 8'h7E, 8'hED, 8'h00));
        send_sample(pack(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_sample(pack(8'hFF, 8'hFF, 8'hF0, 8'hFF, 8'hFF, 8'hF0));
        send_sample(pack(8'h65, 8'h5A, 8'h0F, 8'h7E, 8'hED, 8'h0F));
        send_sample(pack(8'h80, 8'h00, 8'h00, 8'h80, 8'h00, 8'h00));
        send_sample(pack(8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF));
        drain();

        // extremes of calibration: all ones, sign bits only, P1 zero (invalid)
        load_cal('1, '1, '1, '1, '1, '1);
        send_sample(pack(8'h12, 8'h34, 8'h50, 8'h80, 8'h00, 8'h10));
        send_sample(pack(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00));
        drain();
        load_cal(32'h8000_8000, 32'h8000_8000, 32'h8000_8000,
                 32'h8000_8000, 32'h8000_8000, 32'h8000_8000);
        send_sample(pack(8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hF0));
        send_sample(pack(8'hAA, 8'h55, 8'hA5, 8'h55, 8'hAA, 8'h5A));
        drain();
        load_cal({16'd27504, 16'd26435}, {16'h0000, 16'hFC18}, 32'h0, 32'h0, 32'h0, 32'h0);
        send_sample(pack(8'h65, 8'h5A, 8'hC0, 8'h7E, 8'hED, 8'h00));
        drain();

        // random phases: mostly plausible calibration, some fully random
        for (int ph = 0; ph < 12; ph++)
        begin
            if (ph % 3 == 2)
                load_cal($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            else
                load_typical_cal();
            no_idle = (ph == 4);
            for (int k = 0; k < 150; k++)
            begin
                if ($urandom_range(9) < 7)
                    send_sample(typical_sample());
                else
                    send_sample(pack(8'($urandom), 8'($urandom), 8'($urandom),
                                     8'($urandom), 8'($urandom), 8'($urandom)));
                // hold off until the pipeline has fully emptied
                if (k == 75 && ph == 1)
                begin
                    s_axis_tvalid <= 1'b0;
                    while (sb.exp_temp.size() != 0)
                        @(negedge clk);
                end
            end
            no_idle = 1'b0;
            drain();
        end

        $display("Covered %0d sample sets, %0d results checked, %0d invalid pressures,",
                 samples_sent, sb.checked, sb.invalid_seen);
        $display("over zero, extreme, typical and random calibration settings.");
        if (sb.errors == 0 && sb.exp_temp.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
